FILE: rtl/flm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flm_pkg
// Shared types, S-box table and round function of the Feistel/Lai-Massey
// block cipher.
// ----------------------------------------------------------------------------
package flm_pkg;

  localparam int NumCells = 4;
  localparam int BlockW   = 32;
  localparam int HalfW    = 16;

  typedef struct packed {
    logic lm;        // 1: Lai-Massey round, 0: Feistel round
    logic key_hi;    // 1: upper key half, 0: lower key half
    logic swap_out;  // swap halves after the round
  } round_ctl_t;

  typedef struct packed {
    round_ctl_t enc;
    round_ctl_t dec;
  } cell_ctl_t;

  typedef struct packed {
    logic              valid;
    logic              func;
    logic [BlockW-1:0] block;
  } cell_word_t;

  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;

  localparam logic [3:0] Sbox [16] = '{
    4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
    4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3
  };

  function automatic logic [HalfW-1:0] round_sp(input logic [HalfW-1:0] x,
                                                input logic [HalfW-1:0] k);
    logic [HalfW-1:0] v;
    logic [HalfW-1:0] s;
    logic [HalfW-1:0] r;
    int p;
    v = x ^ k;
    for (int i = 0; i < HalfW / 4; i++) begin
      s[4*i +: 4] = Sbox[v[4*i +: 4]];
    end
    r = '0;
    for (int i = 0; i < HalfW; i++) begin
      p = (13 * i + 7) % HalfW;
      r[HalfW-1-p] = s[HalfW-1-i];
    end
    return r;
  endfunction

  // Encrypt: F(K1), F(K2)+swap, LM(K1), LM(K2)
  // Decrypt: LM(K2), LM(K1), F(K2), F(K1)+swap
  function automatic cell_ctl_t cell_ctl(input logic [1:0] stage);
    cell_ctl_t c;
    unique case (stage)
      2'd0: begin
        c.enc = '{lm: 1'b0, key_hi: 1'b1, swap_out: 1'b0};
        c.dec = '{lm: 1'b1, key_hi: 1'b0, swap_out: 1'b0};
      end
      2'd1: begin
        c.enc = '{lm: 1'b0, key_hi: 1'b0, swap_out: 1'b1};
        c.dec = '{lm: 1'b1, key_hi: 1'b1, swap_out: 1'b0};
      end
      2'd2: begin
        c.enc = '{lm: 1'b1, key_hi: 1'b1, swap_out: 1'b0};
        c.dec = '{lm: 1'b0, key_hi: 1'b0, swap_out: 1'b0};
      end
      default: begin
        c.enc = '{lm: 1'b1, key_hi: 1'b0, swap_out: 1'b0};
        c.dec = '{lm: 1'b0, key_hi: 1'b1, swap_out: 1'b1};
      end
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/flm_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flm_round_cell
// One cipher round with a registered output word; the round type, key half
// and output swap come from the control input per direction.
// ----------------------------------------------------------------------------
module flm_round_cell
  import flm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctl_t         ctl,
  input  logic [BlockW-1:0] key,
  input  cell_word_t        word_in,
  output cell_word_t        word_out
);

  round_ctl_t       rc;
  logic [HalfW-1:0] l;
  logic [HalfW-1:0] r;
  logic [HalfW-1:0] k;
  logic [HalfW-1:0] t;
  logic [HalfW-1:0] f;
  logic [BlockW-1:0] rnd;
  logic [BlockW-1:0] block_next;

  always_comb begin
    rc = (word_in.func == FuncDec) ? ctl.dec : ctl.enc;
    l  = word_in.block[BlockW-1:HalfW];
    r  = word_in.block[HalfW-1:0];
    k  = rc.key_hi ? key[BlockW-1:HalfW] : key[HalfW-1:0];
    t  = round_sp(l ^ r, k);
    f  = round_sp(r, k);
    rnd = rc.lm ? {l ^ t, r ^ t} : {r, l ^ f};
    block_next = rc.swap_out ? {rnd[HalfW-1:0], rnd[BlockW-1:HalfW]} : rnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else begin
      word_out.valid <= word_in.valid;
    end
    word_out.func  <= word_in.func;
    word_out.block <= block_next;
  end

endmodule

FILE: rtl/feistel_lai_massey_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feistel_lai_massey_block_cipher
// 32-bit Feistel / Lai-Massey block cipher, one word per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 32-bit key through cfg_we / cfg_wdata while no word is in
//   flight; upper half is the first round key, lower half the second.
//   A word (func, data_block) is taken at a clock edge with start high and
//   busy low; func 0 encrypts, 1 decrypts.
//   The word walks a chain of four round cells, one register each, so
//   done pulses with result_block once the word has left the last cell.
//   A new word may be given every cycle: throughput is one word per
//   cycle, as each of the four registered cells holds its own word.
//   The receiver cannot stall; each result is shown for one cycle only.
//   busy is high only during reset. Reset clears the key to zero and
//   drops all words in flight.
// ----------------------------------------------------------------------------
module feistel_lai_massey_block_cipher
  import flm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic [BlockW-1:0] data_block,
  input  logic              cfg_we,
  input  logic [BlockW-1:0] cfg_wdata,
  output logic              done,
  output logic [BlockW-1:0] result_block
);

  logic [BlockW-1:0] cipher_key;
  cell_word_t        chain [NumCells+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
    end else if (cfg_we) begin
      cipher_key <= cfg_wdata;
    end
  end

  assign busy = rst;

  always_comb begin
    chain[0].valid = start && !busy;
    chain[0].func  = func;
    chain[0].block = data_block;
  end

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    flm_round_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cell_ctl(2'(g))),
      .key      (cipher_key),
      .word_in  (chain[g]),
      .word_out (chain[g+1])
    );
  end

  assign done         = chain[NumCells].valid;
  assign result_block = chain[NumCells].block;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted word did not complete in 4 cycles");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("done without a matching accepted word");

  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done)
    else $error("done right after reset");
`endif

endmodule
